@@ sv/u2g_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package u2g_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_GLYPH,
    CMD_LEAD,
    CMD_LEAD_BYTE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] lead;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] small_glyph;
    logic [7:0] cap_glyph;
  } pair_t;

  localparam logic [7:0] LeadC3 = 8'hC3;
  localparam logic [7:0] LeadC4 = 8'hC4;
  localparam logic [7:0] LeadC5 = 8'hC5;
  localparam logic [7:0] LeadC8 = 8'hC8;

  localparam logic [7:0] LowerA  = 8'h61;
  localparam logic [7:0] LowerZ  = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b == LeadC3) || (b == LeadC4) || (b == LeadC5) || (b == LeadC8);
  endfunction

  function automatic pair_t pair_lookup(input logic [7:0] lead, input logic [7:0] trail);
    pair_t r;
    r = '{hit: 1'b1, small_glyph: 8'h00, cap_glyph: 8'h00};
    case ({lead, trail})
      16'hC582: begin r.small_glyph = 8'hCF; r.cap_glyph = 8'hD0; end
      16'hC581: begin r.small_glyph = 8'hD0; r.cap_glyph = 8'hD0; end
      16'hC584: begin r.small_glyph = 8'hC0; r.cap_glyph = 8'hC1; end
      16'hC583: begin r.small_glyph = 8'hC1; r.cap_glyph = 8'hC1; end
      16'hC59B: begin r.small_glyph = 8'hCB; r.cap_glyph = 8'hCC; end
      16'hC59A: begin r.small_glyph = 8'hCC; r.cap_glyph = 8'hCC; end
      16'hC5BA: begin r.small_glyph = 8'hBB; r.cap_glyph = 8'hBC; end
      16'hC5B9: begin r.small_glyph = 8'hBC; r.cap_glyph = 8'hBC; end
      16'hC5BC: begin r.small_glyph = 8'hB9; r.cap_glyph = 8'hBA; end
      16'hC5BB: begin r.small_glyph = 8'hBA; r.cap_glyph = 8'hBA; end
      16'hC588: begin r.small_glyph = 8'hB4; r.cap_glyph = 8'hB3; end
      16'hC587: begin r.small_glyph = 8'hB3; r.cap_glyph = 8'hB3; end
      16'hC595: begin r.small_glyph = 8'hB6; r.cap_glyph = 8'hB5; end
      16'hC594: begin r.small_glyph = 8'hB5; r.cap_glyph = 8'hB5; end
      16'hC5A1: begin r.small_glyph = 8'hC3; r.cap_glyph = 8'hC2; end
      16'hC5A0: begin r.small_glyph = 8'hC2; r.cap_glyph = 8'hC2; end
      16'hC5A5: begin r.small_glyph = 8'hC6; r.cap_glyph = 8'hC5; end
      16'hC5A4: begin r.small_glyph = 8'hC5; r.cap_glyph = 8'hC5; end
      16'hC5BE: begin r.small_glyph = 8'hC8; r.cap_glyph = 8'hC7; end
      16'hC5BD: begin r.small_glyph = 8'hC7; r.cap_glyph = 8'hC7; end
      16'hC5AE: begin r.small_glyph = 8'hE8; r.cap_glyph = 8'h9D; end
      16'hC5AF: begin r.small_glyph = 8'h9D; r.cap_glyph = 8'h9D; end
      16'hC485: begin r.small_glyph = 8'hB8; r.cap_glyph = 8'hB7; end
      16'hC484: begin r.small_glyph = 8'hB7; r.cap_glyph = 8'hB7; end
      16'hC487: begin r.small_glyph = 8'hBD; r.cap_glyph = 8'hC4; end
      16'hC486: begin r.small_glyph = 8'hC4; r.cap_glyph = 8'hC4; end
      16'hC499: begin r.small_glyph = 8'hD6; r.cap_glyph = 8'hD7; end
      16'hC498: begin r.small_glyph = 8'hD7; r.cap_glyph = 8'hD7; end
      16'hC48D: begin r.small_glyph = 8'hCA; r.cap_glyph = 8'hC9; end
      16'hC48C: begin r.small_glyph = 8'hC9; r.cap_glyph = 8'hC9; end
      16'hC48E: begin r.small_glyph = 8'hD1; r.cap_glyph = 8'hCE; end
      16'hC48F: begin r.small_glyph = 8'hCE; r.cap_glyph = 8'hCE; end
      16'hC4BA: begin r.small_glyph = 8'hD3; r.cap_glyph = 8'hD2; end
      16'hC4B9: begin r.small_glyph = 8'hD2; r.cap_glyph = 8'hD2; end
      16'hC4BE: begin r.small_glyph = 8'hD5; r.cap_glyph = 8'hD4; end
      16'hC4BD: begin r.small_glyph = 8'hD4; r.cap_glyph = 8'hD4; end
      16'hC483: begin r.small_glyph = 8'hF4; r.cap_glyph = 8'hF5; end
      16'hC482: begin r.small_glyph = 8'hF5; r.cap_glyph = 8'hF5; end
      16'hC899: begin r.small_glyph = 8'hEF; r.cap_glyph = 8'hF0; end
      16'hC898: begin r.small_glyph = 8'hF0; r.cap_glyph = 8'hF0; end
      16'hC89B: begin r.small_glyph = 8'hF1; r.cap_glyph = 8'hF2; end
      16'hC89A: begin r.small_glyph = 8'hF2; r.cap_glyph = 8'hF2; end
      16'hC3B3: begin r.small_glyph = 8'hBE; r.cap_glyph = 8'hBF; end
      16'hC393: begin r.small_glyph = 8'hBF; r.cap_glyph = 8'hBF; end
      16'hC3A4: begin r.small_glyph = 8'h84; r.cap_glyph = 8'h8E; end
      16'hC3B6: begin r.small_glyph = 8'h94; r.cap_glyph = 8'h99; end
      16'hC3BC: begin r.small_glyph = 8'h81; r.cap_glyph = 8'h9A; end
      16'hC384: begin r.small_glyph = 8'h8E; r.cap_glyph = 8'h8E; end
      16'hC396: begin r.small_glyph = 8'h99; r.cap_glyph = 8'h99; end
      16'hC39C: begin r.small_glyph = 8'h9A; r.cap_glyph = 8'h9A; end
      16'hC39F: begin r.small_glyph = 8'hE1; r.cap_glyph = 8'hE1; end
      16'hC3A5: begin r.small_glyph = 8'h86; r.cap_glyph = 8'h8F; end
      16'hC385: begin r.small_glyph = 8'h8F; r.cap_glyph = 8'h8F; end
      16'hC3A1: begin r.small_glyph = 8'hD9; r.cap_glyph = 8'hD8; end
      16'hC381: begin r.small_glyph = 8'hD8; r.cap_glyph = 8'hD8; end
      16'hC3A9: begin r.small_glyph = 8'h82; r.cap_glyph = 8'h90; end
      16'hC389: begin r.small_glyph = 8'h90; r.cap_glyph = 8'h90; end
      16'hC3AD: begin r.small_glyph = 8'hDB; r.cap_glyph = 8'hDA; end
      16'hC38D: begin r.small_glyph = 8'hDA; r.cap_glyph = 8'hDA; end
      16'hC3B4: begin r.small_glyph = 8'hDD; r.cap_glyph = 8'hDC; end
      16'hC394: begin r.small_glyph = 8'hDC; r.cap_glyph = 8'hDC; end
      16'hC3BA: begin r.small_glyph = 8'hDF; r.cap_glyph = 8'hDE; end
      16'hC39A: begin r.small_glyph = 8'hDE; r.cap_glyph = 8'hDE; end
      16'hC3BD: begin r.small_glyph = 8'hE3; r.cap_glyph = 8'hE2; end
      16'hC39D: begin r.small_glyph = 8'hE2; r.cap_glyph = 8'hE2; end
      16'hC3A2: begin r.small_glyph = 8'h83; r.cap_glyph = 8'hEE; end
      16'hC382: begin r.small_glyph = 8'hEE; r.cap_glyph = 8'hEE; end
      16'hC3AE: begin r.small_glyph = 8'hED; r.cap_glyph = 8'hF3; end
      16'hC38E: begin r.small_glyph = 8'hF3; r.cap_glyph = 8'hF3; end
      default:  r.hit = 1'b0;
    endcase
    pair_lookup = r;
  endfunction

endpackage

`default_nettype wire

@@ sv/u2g_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u2g_front
  import u2g_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       queue_full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            in_ready,
  output logic            push,
  output cmd_t            push_cmd
);

  logic       lead_held;
  logic       lead_held_next;
  logic [7:0] held_lead_byte;
  logic [7:0] held_lead_byte_next;
  logic       accept;
  logic       starts_pair;
  pair_t      pair;

  assign in_ready    = !queue_full;
  assign accept      = in_valid && in_ready;
  assign starts_pair = is_lead(in_byte) && !in_last;
  assign pair        = pair_lookup(held_lead_byte, in_byte);

  always_comb begin
    lead_held_next      = lead_held;
    held_lead_byte_next = held_lead_byte;
    push                = 1'b0;
    push_cmd.kind       = CMD_BYTE;
    push_cmd.lead       = held_lead_byte;
    push_cmd.data       = in_byte;
    push_cmd.last       = in_last;
    if (accept) begin
      if (lead_held) begin
        lead_held_next = 1'b0;
        push           = 1'b1;
        if (pair.hit) begin
          push_cmd.kind = CMD_GLYPH;
        end else if (starts_pair) begin
          push_cmd.kind       = CMD_LEAD;
          lead_held_next      = 1'b1;
          held_lead_byte_next = in_byte;
        end else begin
          push_cmd.kind = CMD_LEAD_BYTE;
        end
      end else if (starts_pair) begin
        lead_held_next      = 1'b1;
        held_lead_byte_next = in_byte;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_held      <= 1'b0;
      held_lead_byte <= 8'h00;
    end else begin
      lead_held      <= lead_held_next;
      held_lead_byte <= held_lead_byte_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/u2g_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u2g_queue
  import u2g_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output cmd_t      head
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/u2g_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module u2g_back
  import u2g_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       uppercase_mode,
  input  wire logic       not_empty,
  input  wire cmd_t       head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      glyph,
  output logic            out_last
);

  logic       second;
  logic       second_next;
  logic       load;
  logic [7:0] sel_glyph;
  logic       sel_last;
  logic [7:0] byte_out;
  pair_t      pair;

  assign load = not_empty && (!out_valid || out_ready);
  assign pair = pair_lookup(head.lead, head.data);

  always_comb begin
    byte_out = head.data;
    if (uppercase_mode && (head.data >= LowerA) && (head.data <= LowerZ)) begin
      byte_out = head.data - CaseGap;
    end
  end

  always_comb begin
    sel_glyph   = byte_out;
    sel_last    = head.last;
    pop         = load;
    second_next = second;
    case (head.kind)
      CMD_BYTE: begin
      end
      CMD_GLYPH: begin
        sel_glyph = uppercase_mode ? pair.cap_glyph : pair.small_glyph;
      end
      CMD_LEAD: begin
        sel_glyph = head.lead;
        sel_last  = 1'b0;
      end
      CMD_LEAD_BYTE: begin
        if (!second) begin
          sel_glyph = head.lead;
          sel_last  = 1'b0;
          pop       = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      second_next = (head.kind == CMD_LEAD_BYTE) && !second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      second <= second_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph    <= sel_glyph;
      out_last <= sel_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/utf8_to_glyph_transcoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to display-glyph transcoder. Bytes enter on the s_ stream one per cycle; an
// accented-letter lead byte (C3, C4, C5, C8) not flagged last is held until the next
// byte shows whether the pair folds into one glyph. Input is taken at one byte per cycle
// while the two-entry command queue has room; the output register issues one byte per
// cycle while m_tready allows, so a byte that releases an unmatched lead together with
// itself leaves as two output bytes. The first result goes through the command queue
// and then the output register to m_. cfg_data selects uppercase mode and is always
// ready; write it only while the block is idle.

module utf8_to_glyph_transcoder
  import u2g_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // in_last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] glyph
  output logic            m_tlast,   // out_last
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data   // uppercase_mode
);

  logic uppercase_mode;
  logic push;
  logic pop;
  logic full;
  logic not_empty;
  cmd_t push_cmd;
  cmd_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uppercase_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      uppercase_mode <= cfg_data;
    end
  end

  u2g_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .queue_full (full),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .in_ready   (s_tready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  u2g_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  u2g_back u_back (
    .clk            (clk),
    .rst            (rst),
    .uppercase_mode (uppercase_mode),
    .not_empty      (not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .glyph          (m_tdata),
    .out_last       (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/utf8_to_glyph_transcoder_tb.sv @@
`timescale 1ns / 1ps

module utf8_to_glyph_transcoder_tb;
  import u2g_pkg::*;

  localparam int SettleCycles  = 8;
  localparam int StallLimit    = 2000;
  localparam int EndLimit      = 5000;
  localparam int HoldCycles    = 300;
  localparam int PhaseBytes    = 300;
  localparam int DirectedRows  = 25;
  localparam int FoldEntries   = 69;

  // {lead, trail, small glyph, capital glyph}
  localparam logic [31:0] FoldTable [0:FoldEntries-1] = '{
    32'hC582CFD0, 32'hC581D0D0, 32'hC584C0C1, 32'hC583C1C1, 32'hC59BCBCC, 32'hC59ACCCC,
    32'hC5BABBBC, 32'hC5B9BCBC, 32'hC5BCB9BA, 32'hC5BBBABA, 32'hC588B4B3, 32'hC587B3B3,
    32'hC595B6B5, 32'hC594B5B5, 32'hC5A1C3C2, 32'hC5A0C2C2, 32'hC5A5C6C5, 32'hC5A4C5C5,
    32'hC5BEC8C7, 32'hC5BDC7C7, 32'hC5AEE89D, 32'hC5AF9D9D,
    32'hC485B8B7, 32'hC484B7B7, 32'hC487BDC4, 32'hC486C4C4, 32'hC499D6D7, 32'hC498D7D7,
    32'hC48DCAC9, 32'hC48CC9C9, 32'hC48ED1CE, 32'hC48FCECE, 32'hC4BAD3D2, 32'hC4B9D2D2,
    32'hC4BED5D4, 32'hC4BDD4D4, 32'hC483F4F5, 32'hC482F5F5,
    32'hC899EFF0, 32'hC898F0F0, 32'hC89BF1F2, 32'hC89AF2F2,
    32'hC3B3BEBF, 32'hC393BFBF, 32'hC3A4848E, 32'hC3B69499, 32'hC3BC819A, 32'hC3848E8E,
    32'hC3969999, 32'hC39C9A9A, 32'hC39FE1E1, 32'hC3A5868F, 32'hC3858F8F, 32'hC3A1D9D8,
    32'hC381D8D8, 32'hC3A98290, 32'hC3899090, 32'hC3ADDBDA, 32'hC38DDADA, 32'hC3B4DDDC,
    32'hC394DCDC, 32'hC3BADFDE, 32'hC39ADEDE, 32'hC3BDE3E2, 32'hC39DE2E2, 32'hC3A283EE,
    32'hC382EEEE, 32'hC3AEEDF3, 32'hC38EF3F3
  };

  typedef struct packed {
    logic [7:0] glyph;
    logic       last;
  } glyph_out_t;

  typedef struct packed {
    logic       on;
    logic [1:0] n;
    logic [7:0] g0;
    logic       l0;
    logic [7:0] g1;
    logic       l1;
  } glyph_pin_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_b;
    logic       in_l;
    glyph_pin_t pin;
  } script_row_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  glyph_pin_t s_pin;

  glyph_out_t glyph_expect [$];
  logic       upper_mode = 1'b0;
  logic       lead_held  = 1'b0;
  logic [7:0] held_lead  = 8'h00;

  int mismatches    = 0;
  int glyphs_seen   = 0;
  int bytes_taken   = 0;
  int strings_taken = 0;
  int mode_writes   = 0;

  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit rx_hold_req = 1'b0;
  logic cur_mode  = 1'b0;

  script_row_t script [0:DirectedRows-1];

  utf8_to_glyph_transcoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [8:0] fold_pair(input logic [7:0] lead, input logic [7:0] trail,
                                           input logic upper);
    for (int i = 0; i < FoldEntries; i++) begin
      if (FoldTable[i][31:16] == {lead, trail}) begin
        return {1'b1, upper ? FoldTable[i][7:0] : FoldTable[i][15:8]};
      end
    end
    return 9'd0;
  endfunction

  // advance the transcoder state by one byte and queue the glyphs it releases, or the pinned ones if pin.on
  task automatic fold_byte(input logic [7:0] b, input logic last, input glyph_pin_t pin);
    glyph_out_t res [2];
    int         n;
    logic       was_held;
    logic [8:0] pair;
    n        = 0;
    was_held = lead_held;
    pair     = fold_pair(held_lead, b, upper_mode);
    lead_held = 1'b0;
    if (was_held && pair[8]) begin
      res[0] = '{glyph: pair[7:0], last: last};
      n      = 1;
    end else begin
      if (was_held) begin
        res[n] = '{glyph: held_lead, last: 1'b0};
        n++;
      end
      if ((b inside {LeadC3, LeadC4, LeadC5, LeadC8}) && !last) begin
        lead_held = 1'b1;
        held_lead = b;
      end else begin
        res[n] = '{glyph: (upper_mode && b >= LowerA && b <= LowerZ) ? b - CaseGap : b,
                   last: last};
        n++;
      end
    end
    if (pin.on) begin
      if (pin.n > 0) glyph_expect.push_back('{glyph: pin.g0, last: pin.l0});
      if (pin.n > 1) glyph_expect.push_back('{glyph: pin.g1, last: pin.l1});
    end else begin
      for (int i = 0; i < n; i++) glyph_expect.push_back(res[i]);
    end
  endtask

  always @(posedge clk) begin : monitor
    glyph_out_t exp_out;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        upper_mode = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (glyph_expect.size() == 0) begin
          $error("unexpected glyph %02h last %0b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          exp_out = glyph_expect.pop_front();
          glyphs_seen++;
          if (m_tdata !== exp_out.glyph) begin
            $error("glyph: expected %02h, actual %02h", exp_out.glyph, m_tdata);
            mismatches++;
          end
          if (m_tlast !== exp_out.last) begin
            $error("out_last: expected %0b, actual %0b", exp_out.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        fold_byte(s_tdata, s_tlast, s_pin);
        bytes_taken++;
        if (s_tlast) strings_taken++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("utf8_to_glyph_transcoder_tb: errors");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= !(rx_idle_on && $urandom_range(99) < 26);
      end
    end
  end

  function automatic script_row_t step_row(input logic mode, input logic [7:0] b,
                                           input logic last, input logic on,
                                           input logic [1:0] n, input logic [7:0] g0,
                                           input logic l0, input logic [7:0] g1,
                                           input logic l1);
    return '{mode: mode, in_b: b, in_l: last,
             pin: '{on: on, n: n, g0: g0, l0: l0, g1: g1, l1: l1}};
  endfunction

  task automatic send_request(input logic [7:0] b, input logic last, input glyph_pin_t pin);
    while (tx_idle_on && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_pin    <= pin;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the sender until every glyph is out and the pipeline has emptied
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (glyph_expect.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = v;
    mode_writes++;
  endtask

  task automatic send_string();
    logic [7:0] text [$];
    int         tokens;
    int         pick;
    int         idx;
    logic       last;
    tokens = $urandom_range(1, 10);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      idx  = $urandom_range(0, FoldEntries - 1);
      if (pick < 30) begin
        text.push_back($urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                                         : 8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 60) begin
        text.push_back(FoldTable[idx][31:24]);
        text.push_back(FoldTable[idx][23:16]);
      end else if (pick < 70) begin
        text.push_back(FoldTable[idx][31:24]);
        text.push_back(8'($urandom_range(255)));
      end else if (pick < 78) begin
        text.push_back(FoldTable[idx][31:24]);
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    foreach (text[i]) begin
      last = (i == text.size() - 1) || ($urandom_range(99) < 3);
      send_request(text[i], last, '0);
    end
  endtask

  initial begin : stimulus
    int   waited;
    logic phase_mode [6];
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tlast   = 1'b0;
    s_pin     = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    phase_mode = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    script = '{
      step_row(0, 8'h00, 0, 1, 1, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'hFF, 1, 1, 1, 8'hFF, 1, 8'h00, 0),
      step_row(0, 8'h61, 0, 1, 1, 8'h61, 0, 8'h00, 0),
      step_row(0, 8'hC5, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'h82, 1, 0, 0, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'hC3, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'h41, 1, 1, 2, 8'hC3, 0, 8'h41, 1),
      step_row(0, 8'hC4, 1, 1, 1, 8'hC4, 1, 8'h00, 0),
      step_row(0, 8'hC8, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'hC5, 0, 1, 1, 8'hC8, 0, 8'h00, 0),
      step_row(0, 8'h9B, 0, 0, 0, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'hC5, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'hA1, 0, 0, 0, 8'h00, 0, 8'h00, 0),
      step_row(0, 8'h93, 1, 1, 1, 8'h93, 1, 8'h00, 0),
      step_row(1, 8'h7A, 0, 1, 1, 8'h5A, 0, 8'h00, 0),
      step_row(1, 8'h7B, 0, 1, 1, 8'h7B, 0, 8'h00, 0),
      step_row(1, 8'hC5, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(1, 8'h82, 1, 0, 0, 8'h00, 0, 8'h00, 0),
      step_row(1, 8'hC3, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(1, 8'h61, 1, 1, 2, 8'hC3, 0, 8'h41, 1),
      step_row(1, 8'hC5, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(1, 8'hA5, 0, 0, 0, 8'h00, 0, 8'h00, 0),
      step_row(1, 8'h84, 0, 1, 1, 8'h84, 0, 8'h00, 0),
      step_row(1, 8'hC8, 0, 1, 0, 8'h00, 0, 8'h00, 0),
      step_row(1, 8'hC4, 1, 1, 2, 8'hC8, 0, 8'hC4, 1)
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].mode != cur_mode) begin
        drain_block();
        write_mode(script[i].mode);
      end
      send_request(script[i].in_b, script[i].in_l, script[i].pin);
    end

    foreach (phase_mode[p]) begin
      drain_block();
      write_mode(phase_mode[p]);
      tx_idle_on = (p != 0);
      rx_idle_on = (p != 0);
      if (p == 2) rx_hold_req = 1'b1;
      waited = bytes_taken;
      while (bytes_taken - waited < PhaseBytes) send_string();
    end

    s_tvalid <= 1'b0;
    waited = 0;
    while (glyph_expect.size() != 0 && waited < EndLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (glyph_expect.size() != 0) begin
      $error("%0d glyphs never arrived", glyph_expect.size());
      mismatches += glyph_expect.size();
    end
    $display("checked %0d glyphs from %0d bytes in %0d strings, %0d mode writes,",
             glyphs_seen, bytes_taken, strings_taken, mode_writes);
    $display("including a long output hold, a drain pause and a stretch with no idling");
    if (mismatches == 0) begin
      $display("utf8_to_glyph_transcoder_tb: clean");
    end else begin
      $display("utf8_to_glyph_transcoder_tb: errors");
    end
    $finish;
  end

endmodule
